// ===== hw/rtl/tkrle_pkg.sv =====
// Shared types, constants and helpers for the token run-length block indexer.
package tkrle_pkg;

    localparam int TKRLE_MAX_SPLITS = 16;
    localparam int TKRLE_TOKEN_BITS = 16;

    localparam logic [12:0] BLOCK_RUNS_RST = 13'd1024;
    localparam logic [4:0]  SPLIT_COUNT_RST = 5'd0;

    // input op codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TOKEN = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // register index (paddr bit 2)
    localparam logic REG_BLOCK_RUNS  = 1'b0;
    localparam logic REG_SPLIT_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] token;
        logic [7:0]  token_length;
        logic [3:0]  split_slot;
    } t_in_word;

    typedef struct packed {
        logic        kind;
        logic [15:0] run_token;
        logic [31:0] run_offset;
        logic [31:0] block_chars;
        logic [31:0] block_elements;
        logic [47:0] block_weighted;
        logic        segment_end;
        logic [31:0] total_elements;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic [12:0] block_runs;
        logic [4:0]  split_count;
    } t_cfg;

    // how the closed run ends
    typedef enum logic [1:0] {
        CL_NORMAL,
        CL_FULL,
        CL_SPLIT,
        CL_END
    } t_close;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_TOT,
        ST_RUN,
        ST_BLK
    } t_state;

    typedef struct packed {
        logic cap;
        logic do_load;
        logic do_open;
        logic do_repeat;
        logic do_close;
        logic do_acc;
        logic do_tot;
        logic emit_run;
        logic emit_blk;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       run_open;
        logic       tok_eq;
        t_close     cls;
        logic       out_free;
    } t_dp_sts;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// ===== hw/rtl/token_rle_block_indexer.sv =====
// A run record is registered at the output once its closing word has passed MUL1, MUL2, ACC,
// TOT (only when a split marker or end closes the segment) and RUN; a block record follows
// from BLK when the block fills or a split marker or end closes it. RUN and BLK wait while the
// output is stalled, and no new word is taken until the last is done. Load and run-extending
// tokens need only MUL1; the two chained multiplies and saturating sums share one datapath.
// Synchronous active-low reset clears run, segment and config state, not the split marker table.
module token_rle_block_indexer
    import tkrle_pkg::*;
#(
    parameter int MAX_SPLITS = TKRLE_MAX_SPLITS,
    parameter int TOKEN_BITS = TKRLE_TOKEN_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    tkrle_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tkrle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tkrle_dp #(
        .MAX_SPLITS (MAX_SPLITS),
        .TOKEN_BITS (TOKEN_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== hw/rtl/tkrle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tkrle_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tkrle_regs.sv =====
// APB configuration registers: block size and split marker count.
module tkrle_regs
    import tkrle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [12:0] r_block_runs;
    logic [4:0]  r_split_count;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_runs  <= BLOCK_RUNS_RST;
            r_split_count <= SPLIT_COUNT_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_BLOCK_RUNS:  r_block_runs  <= pwdata[12:0];
                REG_SPLIT_COUNT: r_split_count <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_BLOCK_RUNS:  prdata = {19'd0, r_block_runs};
            REG_SPLIT_COUNT: prdata = {27'd0, r_split_count};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.block_runs  = r_block_runs;
    assign o_cfg.split_count = r_split_count;

endmodule

// ===== hw/rtl/tkrle_ctrl.sv =====
// Sequencer for one input word: multiply steps, accumulation and record emission.
module tkrle_ctrl
    import tkrle_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_MUL1;
            end
            ST_MUL1: begin
                priority if (i_sts.op == OP_TOKEN && i_sts.run_open && !i_sts.tok_eq)
                    n_state = ST_MUL2;
                else if (i_sts.op == OP_END && i_sts.run_open)
                    n_state = ST_MUL2;
                else
                    n_state = ST_IDLE;
            end
            ST_MUL2: n_state = ST_ACC;
            ST_ACC: begin
                if (i_sts.cls == CL_SPLIT || i_sts.cls == CL_END) n_state = ST_TOT;
                else n_state = ST_RUN;
            end
            ST_TOT: n_state = ST_RUN;
            ST_RUN: begin
                if (i_sts.out_free) begin
                    n_state = (i_sts.cls == CL_NORMAL) ? ST_IDLE : ST_BLK;
                end
            end
            ST_BLK: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: o_cmd.cap = i_in_valid;
            ST_MUL1: begin
                o_cmd.do_load   = (i_sts.op == OP_LOAD);
                o_cmd.do_open   = (i_sts.op == OP_TOKEN) && !i_sts.run_open;
                o_cmd.do_repeat = (i_sts.op == OP_TOKEN) && i_sts.run_open && i_sts.tok_eq;
            end
            ST_MUL2: o_cmd.do_close = 1'b1;
            ST_ACC:  o_cmd.do_acc   = 1'b1;
            ST_TOT:  o_cmd.do_tot   = 1'b1;
            ST_RUN:  o_cmd.emit_run = i_sts.out_free;
            ST_BLK:  o_cmd.emit_blk = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/tkrle_dp.sv =====
// Datapath: run and segment state, the two multiplies, saturating sums, output word.
module tkrle_dp
    import tkrle_pkg::*;
#(
    parameter int MAX_SPLITS = TKRLE_MAX_SPLITS,
    parameter int TOKEN_BITS = TKRLE_TOKEN_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_word,
    input  t_cfg      i_cfg,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int TW = (TOKEN_BITS < 16) ? TOKEN_BITS : 16;
    localparam int AW = (MAX_SPLITS > 1) ? $clog2(MAX_SPLITS) : 1;
    localparam logic [8:0] MAX_SPLITS_V = 9'(MAX_SPLITS);

    // latched input word
    logic [1:0]    r_op;
    logic [TW-1:0] r_tok;
    logic [7:0]    r_len;
    logic [3:0]    r_slot;

    // run and segment state
    logic          r_run_open;
    logic [TW-1:0] r_cur_tok;
    logic [7:0]    r_cur_len;
    logic [31:0]   r_run_count;
    logic [31:0]   r_seg_chars;
    logic [31:0]   r_seg_elem;
    logic [47:0]   r_weighted;
    logic [12:0]   r_runs;
    logic [31:0]   r_local_off;
    logic [4:0]    r_cursor;
    logic [31:0]   r_grand;

    // multiply pipeline
    logic [31:0]   r_chars;
    logic [44:0]   r_wprod;
    t_close        r_cls;

    logic          r_out_valid;
    t_out_word     r_out_word;

    logic [39:0]   w_cprod;
    logic [44:0]   w_wprod;
    logic [13:0]   w_runs_inc;
    logic [48:0]   w_wsum;
    logic          w_hit;
    logic          w_out_free;
    logic [TW-1:0] w_rdata;
    logic [8:0]    w_slot_ext;
    logic [8:0]    w_cur_ext;
    logic          w_we;

    assign w_slot_ext = {5'd0, r_slot};
    assign w_cur_ext  = {4'd0, r_cursor};
    assign w_we       = i_cmd.do_load && (w_slot_ext < MAX_SPLITS_V);

    tkrle_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_SPLITS)
    ) u_split_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_slot_ext[AW-1:0]),
        .i_wdata (r_tok),
        .i_raddr (w_cur_ext[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_cprod    = 40'(r_run_count) * 40'(r_cur_len);
    assign w_wprod    = 45'(r_chars) * 45'(r_runs);
    assign w_runs_inc = 14'(r_runs) + 14'd1;
    assign w_wsum     = 49'(r_weighted) + 49'(r_wprod);
    assign w_hit      = (r_op == OP_TOKEN) && (r_cursor < i_cfg.split_count)
                        && (w_cur_ext < MAX_SPLITS_V) && (r_tok == w_rdata);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op   <= i_in_word.op;
            r_tok  <= i_in_word.token[TW-1:0];
            r_len  <= i_in_word.token_length;
            r_slot <= i_in_word.split_slot;
        end
        r_chars <= (|w_cprod[39:32]) ? 32'hFFFF_FFFF : w_cprod[31:0];
        r_wprod <= w_wprod;
        if (i_cmd.do_close) begin
            priority if (r_op == OP_END) r_cls <= CL_END;
            else if (w_hit) r_cls <= CL_SPLIT;
            else if (w_runs_inc >= {1'b0, i_cfg.block_runs}) r_cls <= CL_FULL;
            else r_cls <= CL_NORMAL;
        end
        if (i_cmd.emit_run) begin
            r_out_word.kind           <= 1'b0;
            r_out_word.run_token      <= 16'(r_cur_tok);
            r_out_word.run_offset     <= (r_cls == CL_NORMAL || r_cls == CL_END)
                                         ? r_local_off : 32'd0;
            r_out_word.block_chars    <= '0;
            r_out_word.block_elements <= '0;
            r_out_word.block_weighted <= '0;
            r_out_word.segment_end    <= 1'b0;
            r_out_word.total_elements <= '0;
            r_out_word.last           <= (r_cls == CL_NORMAL);
        end else if (i_cmd.emit_blk) begin
            r_out_word.kind           <= 1'b1;
            r_out_word.run_token      <= '0;
            r_out_word.run_offset     <= '0;
            r_out_word.block_chars    <= r_seg_chars;
            r_out_word.block_elements <= r_seg_elem;
            r_out_word.block_weighted <= r_weighted;
            r_out_word.segment_end    <= (r_cls == CL_SPLIT || r_cls == CL_END);
            r_out_word.total_elements <= r_grand;
            r_out_word.last           <= 1'b1;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open  <= 1'b0;
            r_cur_tok   <= '0;
            r_cur_len   <= '0;
            r_run_count <= '0;
            r_seg_chars <= '0;
            r_seg_elem  <= '0;
            r_weighted  <= '0;
            r_runs      <= '0;
            r_local_off <= '0;
            r_cursor    <= '0;
            r_grand     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.do_open) begin
                r_run_open  <= 1'b1;
                r_cur_tok   <= r_tok;
                r_cur_len   <= r_len;
                r_run_count <= 32'd1;
            end
            if (i_cmd.do_repeat) begin
                r_run_count <= sat_add32(r_run_count, 32'd1);
            end
            if (i_cmd.do_close) begin
                r_local_off <= sat_add32(r_local_off, r_chars);
                r_seg_chars <= sat_add32(r_seg_chars, r_chars);
                r_runs      <= w_runs_inc[12:0];
                r_run_open  <= 1'b0;
            end
            if (i_cmd.do_acc) begin
                r_weighted <= w_wsum[48] ? 48'hFFFF_FFFF_FFFF : w_wsum[47:0];
                if (r_cls != CL_NORMAL) begin
                    r_seg_elem <= sat_add32(r_seg_elem, 32'(r_runs));
                end
            end
            if (i_cmd.do_tot) begin
                r_grand <= sat_add32(r_grand, r_seg_elem);
            end
            // after a normal or full-block close, the new token opens its run once the closed one is out
            if ((i_cmd.emit_run && r_cls == CL_NORMAL) ||
                (i_cmd.emit_blk && r_cls == CL_FULL)) begin
                r_run_open  <= 1'b1;
                r_cur_tok   <= r_tok;
                r_cur_len   <= r_len;
                r_run_count <= 32'd1;
            end
            if (i_cmd.emit_blk) begin
                r_weighted  <= '0;
                r_runs      <= '0;
                r_local_off <= '0;
                if (r_cls != CL_FULL) begin
                    r_seg_chars <= '0;
                    r_seg_elem  <= '0;
                end
                if (r_cls == CL_SPLIT) begin
                    r_cursor <= r_cursor + 5'd1;
                end
            end
            if (i_cmd.emit_run || i_cmd.emit_blk) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.run_open = r_run_open;
    assign o_sts.tok_eq   = (r_tok == r_cur_tok);
    assign o_sts.cls      = r_cls;
    assign o_sts.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== hw/rtl/tkrle_chk.sv =====
// Port-level checker for the token run-length block indexer, bound to the top level.
module tkrle_chk
    import tkrle_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // reset leaves the block empty and ready
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not idle after reset");

    // at most one word in flight on the input side
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");

    // no record can appear the cycle after a word is taken
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("output too early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word dropped or changed");

endmodule

bind token_rle_block_indexer tkrle_chk u_chk (.*);
